// ===== src/first_fit_bin_packer_defines.svh =====
// Assertion macros for the first-fit bin packer.
// No dependencies; included by the modules that carry assertions.
`ifndef FIRST_FIT_BIN_PACKER_DEFINES_SVH
`define FIRST_FIT_BIN_PACKER_DEFINES_SVH

`ifndef SYNTHESIS
// Concurrent assertion on an explicit clock and active-low reset
`define FFBP_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Concurrent assertion on the module's clk_i / rst_ni
`define FFBP_ASSERT(lbl, prop, msg) \
  `FFBP_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)
`else
`define FFBP_ASSERT_CLK(lbl, clk, rstn, prop, msg)
`define FFBP_ASSERT(lbl, prop, msg)
`endif

`endif

// ===== src/ffbp_pkg.sv =====
// Shared types and constants for the first-fit bin packer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package ffbp_pkg;

  // Bin table size and derived widths
  localparam int MAX_BINS  = 64;
  localparam int BIN_W     = $clog2(MAX_BINS);
  localparam int CNT_W     = $clog2(MAX_BINS + 1);
  localparam int OUT_BIN_W = 6;

  // Configuration register map
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIN_CAPACITY = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BUDGET_LIMIT = 1'd1;

  localparam logic [15:0] CAPACITY_RESET = 16'd1572;
  localparam logic [31:0] BUDGET_RESET   = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [15:0] item_id;
    logic [15:0] item_weight;
    logic        check_budget;
  } item_t;

  typedef struct packed {
    logic [15:0]          placed_id;
    logic [OUT_BIN_W-1:0] bin_index;
    logic                 placed;
    logic                 opened_bin;
    logic                 over_budget;
    logic                 table_full;
    logic [31:0]          total_packed;
  } result_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic load_item;
    logic scan_init;
    logic scan_run;
    logic commit_fit;
    logic commit_open;
    logic reject_over;
    logic reject_full;
  } ctrl_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic over_budget;
    logic fit_hit;
    logic scan_done;
    logic table_full;
  } dp_status_t;

endpackage

// ===== src/ffbp_datapath.sv =====
// Datapath of the first-fit bin packer: config registers, bin fill memory,
// scan counter, budget and fit compares, totals and the result register.
// Depends on ffbp_pkg.
`timescale 1ns / 1ps

module ffbp_datapath
  import ffbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  input  item_t                item_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_status_t           status_o,
  output result_t              result_o
);

  logic [15:0]      capacity_q;
  logic [31:0]      budget_q;
  item_t            item_q;
  logic [31:0]      total_q, total_d;
  logic [CNT_W-1:0] bins_open_q;
  logic [CNT_W-1:0] rd_idx_q;
  logic [BIN_W-1:0] cmp_idx_q;
  logic             pend_q;
  logic [15:0]      rd_data_q;
  logic             rd_vld_q;
  logic [MAX_BINS-1:0] fill_vld_q;
  logic [15:0]      fill_mem [MAX_BINS];
  result_t          result_q;

  logic [32:0]      sum_total;
  logic [15:0]      cur_fill;
  logic [16:0]      fit_sum;
  logic             rd_en;
  logic             wr_en;
  logic [BIN_W-1:0] wr_addr;
  logic [15:0]      wr_data;
  logic [BIN_W-1:0] open_idx;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAPACITY_RESET;
      budget_q   <= BUDGET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_BIN_CAPACITY: capacity_q <= cfg_data_i[15:0];
        CFG_BUDGET_LIMIT: budget_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Item capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      item_q <= item_i;
    end
  end

  // Budget test and saturating total
  assign sum_total = {1'b0, total_q} + {17'd0, item_q.item_weight};
  assign total_d   = sum_total[32] ? 32'hFFFF_FFFF : sum_total[31:0];

  // Fit compare on the registered fill read
  assign cur_fill = rd_vld_q ? rd_data_q : 16'd0;
  assign fit_sum  = {1'b0, cur_fill} + {1'b0, item_q.item_weight};

  assign rd_en = cmd_i.scan_run && (rd_idx_q < bins_open_q);

  assign status_o.over_budget = item_q.check_budget && (sum_total > {1'b0, budget_q});
  assign status_o.fit_hit     = pend_q && (fit_sum <= {1'b0, capacity_q});
  assign status_o.scan_done   = !pend_q && !(rd_idx_q < bins_open_q);
  assign status_o.table_full  = (bins_open_q == CNT_W'(MAX_BINS));

  // Scan counter: one read issued per cycle, compared in the cycle after
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q  <= '0;
      cmp_idx_q <= '0;
      pend_q    <= 1'b0;
    end else if (cmd_i.scan_init) begin
      rd_idx_q <= '0;
      pend_q   <= 1'b0;
    end else if (cmd_i.scan_run) begin
      pend_q <= rd_en;
      if (rd_en) begin
        rd_idx_q  <= rd_idx_q + CNT_W'(1);
        cmp_idx_q <= rd_idx_q[BIN_W-1:0];
      end
    end
  end

  // Bin fill memory
  assign open_idx = bins_open_q[BIN_W-1:0];
  assign wr_en    = cmd_i.commit_fit || cmd_i.commit_open;
  assign wr_addr  = cmd_i.commit_fit ? cmp_idx_q : open_idx;
  assign wr_data  = cmd_i.commit_fit ? fit_sum[15:0] : item_q.item_weight;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      fill_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_data_q <= fill_mem[rd_idx_q[BIN_W-1:0]];
    end
  end

  // Entry valid bits; an unwritten bin reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_vld_q <= '0;
      rd_vld_q   <= 1'b0;
    end else begin
      if (wr_en) begin
        fill_vld_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= fill_vld_q[rd_idx_q[BIN_W-1:0]];
      end
    end
  end

  // Bin count and packed total
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bins_open_q <= CNT_W'(1);
      total_q     <= '0;
    end else begin
      if (cmd_i.commit_open) begin
        bins_open_q <= bins_open_q + CNT_W'(1);
      end
      if (wr_en) begin
        total_q <= total_d;
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (wr_en || cmd_i.reject_over || cmd_i.reject_full) begin
      result_q.placed_id    <= item_q.item_id;
      result_q.bin_index    <= cmd_i.commit_fit  ? OUT_BIN_W'(cmp_idx_q) :
                               cmd_i.commit_open ? OUT_BIN_W'(open_idx) : '0;
      result_q.placed       <= wr_en;
      result_q.opened_bin   <= cmd_i.commit_open;
      result_q.over_budget  <= cmd_i.reject_over;
      result_q.table_full   <= cmd_i.reject_full;
      result_q.total_packed <= wr_en ? total_d : total_q;
    end
  end

  assign result_o = result_q;

endmodule

// ===== src/ffbp_ctrl.sv =====
// Controller of the first-fit bin packer: sequences budget check, bin scan
// and commit, and raises the one-cycle result strobe.
// Depends on ffbp_pkg and first_fit_bin_packer_defines.svh.
`timescale 1ns / 1ps
`include "first_fit_bin_packer_defines.svh"

module ffbp_ctrl
  import ffbp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output ctrl_cmd_t  cmd_o,
  output logic       busy_o,
  output logic       result_valid_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCAN
  } state_e;

  state_e state_q, state_d;
  logic   valid_q, valid_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    valid_d = 1'b0;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.over_budget) begin
          cmd_o.reject_over = 1'b1;
          valid_d           = 1'b1;
          state_d           = ST_IDLE;
        end else begin
          cmd_o.scan_init = 1'b1;
          state_d         = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan_run = 1'b1;
        if (status_i.fit_hit) begin
          cmd_o.commit_fit = 1'b1;
          valid_d          = 1'b1;
          state_d          = ST_IDLE;
        end else if (status_i.scan_done) begin
          if (status_i.table_full) begin
            cmd_o.reject_full = 1'b1;
          end else begin
            cmd_o.commit_open = 1'b1;
          end
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign result_valid_o = valid_q;

  `FFBP_ASSERT(a_strobe_single, valid_q |=> !valid_q, "result strobe held two cycles")
  `FFBP_ASSERT(a_accept_busy, (start_i && !busy_o) |=> busy_o, "accepted item not busy")
  `FFBP_ASSERT(a_strobe_idle, valid_q |-> (state_q == ST_IDLE), "strobe while working")

endmodule

// ===== src/first_fit_bin_packer.sv =====
// Top level of the first-fit bin packer: controller plus datapath.
// Depends on ffbp_pkg, ffbp_ctrl and ffbp_datapath.
//
// Channel   Handshake                      Payload
// --------  -----------------------------  -----------------------------
// item      start, busy                    item_i (item_t)
// result    result_valid_o (1-cycle)       result_o (result_t)
// config    cfg_valid_i, cfg_ready_o       cfg_index_i, cfg_data_i
//
// The strobe follows the check state for an over-budget item; otherwise the
// open bins are scanned in order and the strobe follows the first bin that
// fits, or the end of the scan when none of them fits (new bin or table full).
// The bin scan reads one fill a cycle from the fill memory.
// busy falls in the strobe cycle; a new start is taken that cycle.
// The result lasts one cycle and cannot be stalled; register writes are
// taken only while busy is low.
// Reset is asynchronous; no clearing pass, the bin table is ready at once.
`timescale 1ns / 1ps

module first_fit_bin_packer
  import ffbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  item_t                item_i,
  output logic                 result_valid_o,
  output result_t              result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  // Register writes are taken only with no item in flight
  assign cfg_ready_o = !busy;

  ffbp_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start),
    .status_i       (status),
    .cmd_o          (cmd),
    .busy_o         (busy),
    .result_valid_o (result_valid_o)
  );

  ffbp_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .item_i      (item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .result_o    (result_o)
  );

endmodule

// ===== sim/ffbp_checker.sv =====
// Scoreboard for the first-fit bin packer: watches items, register writes and results.
// Keeps its own copy of the bin table and predicts every result. Depends on ffbp_pkg.
`timescale 1ns / 1ps

module ffbp_checker
  import ffbp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 item_start_i,
  input  logic                 item_busy_i,
  input  item_t                item_i,
  input  logic                 res_valid_i,
  input  result_t              res_i,
  input  logic                 cfg_valid_i,
  input  logic                 cfg_ready_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]          cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  // Shadow copy of the registers and the bin table
  logic [15:0]  capacity;
  logic [31:0]  budget;
  logic [15:0]  fills [MAX_BINS];
  int unsigned  open_bins;
  logic [31:0]  packed_sum;

  result_t      placement_q [$];
  result_t      want;
  int           fail_count  = 0;
  int           outstanding = 0;

  assign fail_count_o = fail_count;
  assign pending_o    = outstanding;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    $display("%0t ns  mismatch: %s: got %0h, expected %0h", $time, what, got, exp_val);
    fail_count++;
  endtask

  task automatic check_field(input string name, input logic [15:0] id,
                             input logic [31:0] got, input logic [31:0] exp_val);
    if (got !== exp_val) begin
      report_mismatch($sformatf("item %04h %s", id, name), got, exp_val);
    end
  endtask

  // First-fit placement: budget test first, then scan open bins, then open one
  function automatic result_t place_item(input item_t it);
    result_t     r;
    logic [32:0] sum;
    int          hit;
    int unsigned j;
    int unsigned slot;
    r             = '0;
    r.placed_id   = it.item_id;
    sum           = {1'b0, packed_sum} + {17'd0, it.item_weight};
    hit           = -1;
    slot          = 0;
    if (it.check_budget && (sum > {1'b0, budget})) begin
      r.over_budget = 1'b1;
    end else begin
      for (j = 0; (j < open_bins) && (hit < 0); j++) begin
        if (({1'b0, fills[j]} + {1'b0, it.item_weight}) <= {1'b0, capacity}) begin
          hit = j;
        end
      end
      if (hit >= 0) begin
        slot        = hit;
        fills[slot] = fills[slot] + it.item_weight;
        r.placed    = 1'b1;
      end else if (open_bins < MAX_BINS) begin
        slot         = open_bins;
        fills[slot]  = it.item_weight;
        open_bins++;
        r.placed     = 1'b1;
        r.opened_bin = 1'b1;
      end else begin
        r.table_full = 1'b1;
      end
      if (r.placed) begin
        packed_sum = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      end
    end
    r.bin_index    = slot[OUT_BIN_W-1:0];
    r.total_packed = packed_sum;
    return r;
  endfunction

  // Results first, then register writes, then the newly accepted item
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity   = CAPACITY_RESET;
      budget     = BUDGET_RESET;
      open_bins  = 1;
      packed_sum = '0;
      for (int k = 0; k < MAX_BINS; k++) fills[k] = '0;
      placement_q.delete();
      outstanding = 0;
    end else begin
      if (res_valid_i) begin
        if (placement_q.size() == 0) begin
          report_mismatch("result with no item outstanding", res_i.placed_id, '0);
        end else begin
          want = placement_q.pop_front();
          check_field("placed_id", want.placed_id, res_i.placed_id, want.placed_id);
          check_field("bin_index", want.placed_id, res_i.bin_index, want.bin_index);
          check_field("placed", want.placed_id, res_i.placed, want.placed);
          check_field("opened_bin", want.placed_id, res_i.opened_bin, want.opened_bin);
          check_field("over_budget", want.placed_id, res_i.over_budget, want.over_budget);
          check_field("table_full", want.placed_id, res_i.table_full, want.table_full);
          check_field("total_packed", want.placed_id, res_i.total_packed,
                      want.total_packed);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_BIN_CAPACITY: begin
            capacity = cfg_data_i[15:0];
          end
          CFG_BUDGET_LIMIT: begin
            budget = cfg_data_i;
          end
          default: begin
          end
        endcase
      end
      if (item_start_i && !item_busy_i) begin
        placement_q = {placement_q, place_item(item_i)};
      end
      outstanding = placement_q.size();
    end
  end

endmodule

// ===== sim/first_fit_bin_packer_test.sv =====
// Testbench top for the first-fit bin packer: clock, reset, stimulus and verdict.
// Depends on ffbp_pkg, first_fit_bin_packer and the ffbp_checker scoreboard.
`timescale 1ns / 1ps

module first_fit_bin_packer_test;
  import ffbp_pkg::*;

  localparam int WATCHDOG_LIMIT  = 2000;
  localparam int DRAIN_CYCLES    = 70;
  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 104;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 start       = 1'b0;
  logic                 busy;
  item_t                item_i      = '0;
  logic                 result_valid_o;
  result_t              result_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = CFG_BIN_CAPACITY;
  logic [31:0]          cfg_data_i  = '0;

  int          fail_count;
  int          pending;
  int          stall_cycles = 0;
  bit          gaps_on      = 1'b0;
  logic [15:0] cur_capacity = CAPACITY_RESET;
  logic [31:0] total_seen   = '0;

  always #10 clk_i = ~clk_i;

  first_fit_bin_packer dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  ffbp_checker scoreboard (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_start_i (start),
    .item_busy_i  (busy),
    .item_i       (item_i),
    .res_valid_i  (result_valid_o),
    .res_i        (result_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Running total as reported, used to aim the budget limit
  always @(posedge clk_i) begin
    if (result_valid_o) begin
      total_seen <= result_o.total_packed;
    end
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("first_fit_bin_packer_test: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // All tasks are entered and left at a falling edge
  // busy only moves at a rising edge, so its value at the falling edge
  // tells whether the next rising edge takes the item
  task automatic send_item(input logic [15:0] id, input logic [15:0] weight,
                           input logic chk);
    logic taken;
    start  <= 1'b1;
    item_i <= '{item_id: id, item_weight: weight, check_budget: chk};
    do begin
      taken = !busy;
      @(negedge clk_i);
    end while (!taken);
  endtask

  task automatic maybe_pause();
    if (gaps_on && ($urandom_range(0, 4) == 0)) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    logic taken;
    if (gaps_on) begin
      repeat ($urandom_range(1, 15)) @(negedge clk_i);
    end
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      taken = cfg_ready_o;
      @(negedge clk_i);
    end while (!taken);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
    if (idx == CFG_BIN_CAPACITY) cur_capacity = data[15:0];
  endtask

  // Mostly light items, some up to a bin's capacity, a few of any size
  function automatic logic [15:0] pick_weight();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return 16'($urandom_range(0, 255));
    else if (sel < 8) return 16'($urandom_range(0, cur_capacity));
    else return 16'($urandom_range(0, 65535));
  endfunction

  initial begin : stimulus
    logic [15:0] phase_caps [RANDOM_PHASES];
    phase_caps = '{16'd1572, 16'd900, 16'd3000, 16'd0, 16'd1, 16'd0, 16'd65535, 16'd1572};
    phase_caps[3] = 16'($urandom_range(1, 65535));

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: exact fit, new bins, oversized item, first-fit order
    send_item(16'h0000, 16'd0,     1'b0);
    send_item(16'hFFFF, 16'd1572,  1'b1);
    send_item(16'h1234, 16'd1,     1'b0);
    send_item(16'hABCD, 16'hFFFF,  1'b1);
    send_item(16'h5555, 16'd1571,  1'b0);
    send_item(16'hAAAA, 16'd0,     1'b1);
    send_item(16'h00FF, 16'h5555,  1'b0);
    send_item(16'hFF00, 16'hAAAA,  1'b1);

    // Budget rejects ahead of the fit test; exact budget still passes
    wait_idle();
    write_reg(CFG_BUDGET_LIMIT, total_seen + 32'd10);
    send_item(16'h0101, 16'd11,    1'b1);
    send_item(16'h0102, 16'd10,    1'b1);
    send_item(16'h0103, 16'd0,     1'b1);
    send_item(16'h0104, 16'd500,   1'b0);
    send_item(16'h0105, 16'd0,     1'b1);
    wait_idle();
    write_reg(CFG_BUDGET_LIMIT, 32'd0);
    send_item(16'h0201, 16'd0,     1'b1);
    send_item(16'h0202, 16'd7,     1'b0);

    // Zero capacity: only weight-zero items into an empty bin
    wait_idle();
    write_reg(CFG_BIN_CAPACITY, {16'hFFFF, 16'd0});
    write_reg(CFG_BUDGET_LIMIT, BUDGET_RESET);
    send_item(16'h0301, 16'd0,     1'b0);
    send_item(16'h0302, 16'd0,     1'b1);
    send_item(16'h0303, 16'd1,     1'b0);

    // Largest capacity
    wait_idle();
    write_reg(CFG_BIN_CAPACITY, {16'hA5A5, 16'hFFFF});
    send_item(16'h0401, 16'hFFFF,  1'b1);
    send_item(16'h0402, 16'd2,     1'b0);

    // Random phases, each with its own capacity and budget
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      gaps_on = (phase < RANDOM_PHASES - 1) && ((phase % 3) != 2);
      write_reg(CFG_BIN_CAPACITY, {16'($urandom_range(0, 65535)), phase_caps[phase]});
      case ($urandom_range(0, 3))
        0: write_reg(CFG_BUDGET_LIMIT, BUDGET_RESET);
        1: write_reg(CFG_BUDGET_LIMIT, total_seen + $urandom_range(0, 3000));
        2: write_reg(CFG_BUDGET_LIMIT, $urandom());
        default: write_reg(CFG_BUDGET_LIMIT, total_seen + $urandom_range(0, 200));
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        // Hold off once mid-phase until every outstanding result is back
        if ((phase == 2) && (n == ITEMS_PER_PHASE / 2)) wait_idle();
        maybe_pause();
        send_item(16'($urandom_range(0, 65535)), pick_weight(), 1'($urandom_range(0, 1)));
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if ((fail_count == 0) && (pending == 0)) begin
      $display("first_fit_bin_packer_test: PASS");
    end else begin
      $display("first_fit_bin_packer_test: FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/ffbp_pkg.sv
src/ffbp_datapath.sv
src/ffbp_ctrl.sv
src/first_fit_bin_packer.sv
sim/ffbp_checker.sv
sim/first_fit_bin_packer_test.sv
